FILE: rtl/rsht_pkg.sv
package rsht_pkg;

    // Shape codes on the input word
    typedef enum logic [1:0] {
        KIND_RECT   = 2'd0,
        KIND_CIRCLE = 2'd1,
        KIND_TRI    = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CSTART,
        ST_CWAIT,
        ST_MUL,
        ST_FIN,
        ST_OUT
    } state_t;

    localparam int ANG_W        = 20;   // full turn = 2^20
    localparam int CS_W         = 33;   // Q1.30 sine/cosine with headroom
    localparam int Z_W          = 22;   // residual angle
    localparam int ATAN_W       = 18;
    localparam int OP_W         = 17;   // signed Q.4 offsets before rotation
    localparam int PROD_W       = OP_W + CS_W;
    localparam int COORD_W      = 20;
    localparam int SIZE_W       = 12;
    localparam int TEX_W        = 9;
    localparam int COLOR_W      = 32;
    localparam int IDX_W        = 16;
    localparam int RIM_SIDES_DEF = 32;

    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [COLOR_W-1:0]     YELLOW      = 32'hFFFF00FF;

    // Arctangent of 2^-k in 2^20 turn units
    function automatic logic [ATAN_W-1:0] atan_step(input logic [3:0] k);
        logic [ATAN_W-1:0] r;
        begin
            unique case (k)
                4'd0:  r = 18'd131072;
                4'd1:  r = 18'd77376;
                4'd2:  r = 18'd40884;
                4'd3:  r = 18'd20753;
                4'd4:  r = 18'd10417;
                4'd5:  r = 18'd5213;
                4'd6:  r = 18'd2607;
                4'd7:  r = 18'd1304;
                4'd8:  r = 18'd652;
                4'd9:  r = 18'd326;
                4'd10: r = 18'd163;
                4'd11: r = 18'd81;
                4'd12: r = 18'd41;
                4'd13: r = 18'd20;
                4'd14: r = 18'd10;
                4'd15: r = 18'd5;
                default: r = 18'd0;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: rtl/rsht_cordic.sv
module rsht_cordic (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [rsht_pkg::ANG_W-1:0]         angle,
    output logic                               done,
    output logic signed [rsht_pkg::CS_W-1:0]   cos_val,
    output logic signed [rsht_pkg::CS_W-1:0]   sin_val
);
    import rsht_pkg::*;

    logic signed [CS_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [CS_W-1:0] cos_reg, cos_next, sin_reg, sin_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic [3:0]             k_reg, k_next;
    logic                   busy_reg, busy_next;
    logic                   neg_reg, neg_next;
    logic                   done_reg, done_next;
    logic [ANG_W-1:0]       folded;
    logic signed [CS_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  at;

    assign done    = done_reg;
    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

    // Fold the left half-plane onto the right one
    assign folded = (angle[19] ^ angle[18]) ? {~angle[19], angle[18:0]} : angle;
    assign xs = x_reg >>> k_reg;
    assign ys = y_reg >>> k_reg;
    assign at = Z_W'(signed'({1'b0, atan_step(k_reg)}));

    // One micro-rotation per cycle
    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        cos_next  = cos_reg;
        sin_next  = sin_reg;
        if (start) begin
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            z_next    = Z_W'(signed'(folded));
            k_next    = '0;
            busy_next = 1'b1;
            neg_next  = angle[19] ^ angle[18];
        end else if (busy_reg) begin
            if (!z_reg[Z_W-1]) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            k_next = k_reg + 4'd1;
            if (k_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                cos_next  = neg_reg ? -x_next : x_next;
                sin_next  = neg_reg ? -y_next : y_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        k_reg   <= k_next;
        neg_reg <= neg_next;
        cos_reg <= cos_next;
        sin_reg <= sin_next;
    end

endmodule

FILE: rtl/rotated_shape_tessellator.sv
// Rotated shape tessellator.
// Input channel (s_*): one word per shape (rectangle, circle or triangle)
// with center, size, binary angle, color, highlight and restart flags.
// Output channel (m_*): one word per vertex, m_last on the final vertex.
// Vertices of a polygon are rotated about the center; a circle gives its
// truncated center, then RIM_SIDES+1 rim points closing the fan.
// Timing: every sine/cosine pair comes from an iterative CORDIC, one
// micro-rotation per cycle, and each vertex but a circle's center goes
// through one shared multiplier, then a finish step. A rectangle or a
// triangle computes its sine/cosine pair once; a circle computes a pair
// per rim point. Shape kind 3 emits nothing and leaves the block idle.
// s_ready is high only while no shape is in work. Each vertex waits on
// m_valid until m_ready; a stalled receiver stops the sequencer, nothing
// is dropped. Reset (aresetn low, synchronous) clears the vertex counter
// and returns the block to idle.
module rotated_shape_tessellator #(
    parameter int RIM_SIDES = rsht_pkg::RIM_SIDES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_shape_kind,
    input  logic signed [rsht_pkg::COORD_W-1:0]  s_center_x,
    input  logic signed [rsht_pkg::COORD_W-1:0]  s_center_y,
    input  logic [rsht_pkg::SIZE_W-1:0]          s_size_w,
    input  logic [rsht_pkg::SIZE_W-1:0]          s_size_h,
    input  logic [15:0]                          s_angle,
    input  logic [rsht_pkg::COLOR_W-1:0]         s_rgba,
    input  logic                                 s_highlight,
    input  logic                                 s_restart,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [rsht_pkg::IDX_W-1:0]           m_vertex_index,
    output logic signed [rsht_pkg::COORD_W-1:0]  m_pos_x,
    output logic signed [rsht_pkg::COORD_W-1:0]  m_pos_y,
    output logic [rsht_pkg::TEX_W-1:0]           m_tex_u,
    output logic [rsht_pkg::TEX_W-1:0]           m_tex_v,
    output logic [rsht_pkg::COLOR_W-1:0]         m_vertex_rgba,
    output logic                                 m_last
);
    import rsht_pkg::*;

    localparam int VTX_W   = $clog2(RIM_SIDES + 2);
    localparam int OFF_STEP = (1 << ANG_W) / RIM_SIDES;
    localparam int OFF_FRAC = (1 << ANG_W) % RIM_SIDES;
    localparam int REM_W   = $clog2(2 * RIM_SIDES);
    localparam int ACC_W   = PROD_W + 1;
    localparam int RND_W   = ACC_W - 30;
    localparam int BASE_W  = COORD_W + 1;
    localparam int SUM_W   = COORD_W + 3;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd536870912);
    localparam logic [VTX_W-1:0] VTX_CIRC_LAST = VTX_W'(RIM_SIDES + 1);

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;
    logic signed [BASE_W-1:0] bx_reg, bx_next, by_reg, by_next;
    logic [SIZE_W-1:0]  w_reg, w_next, h_reg, h_next;
    logic [ANG_W-1:0]   a_reg, a_next;
    logic [COLOR_W-1:0] rgba_reg, rgba_next;
    logic [VTX_W-1:0]   vtx_reg, vtx_next;
    logic [2:0]         step_reg, step_next;
    logic [IDX_W-1:0]   count_reg, count_next;
    logic [ANG_W:0]     off_reg, off_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next, acc_reg, acc_next;
    logic signed [ACC_W-1:0]  accx_reg, accx_next, accy_reg, accy_next;
    logic signed [COORD_W-1:0] px_out_reg, px_out_next, py_out_reg, py_out_next;
    logic [TEX_W-1:0]   u_reg, u_next, v_reg, v_next;
    logic               last_reg, last_next;

    logic                   cord_start, cord_done;
    logic [ANG_W-1:0]       cord_angle;
    logic signed [CS_W-1:0] cos_v, sin_v;
    logic signed [OP_W-1:0] op_x, op_y, hw, hh, r4, mul_a;
    logic signed [CS_W-1:0] mul_b;
    logic [REM_W-1:0]       rem_sum;
    logic signed [BASE_W-1:0] cxe, cye, ncx, ncy, tcx, tcy;

    rsht_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start),
        .angle   (cord_angle),
        .done    (cord_done),
        .cos_val (cos_v),
        .sin_val (sin_v)
    );

    // Truncate a Q16.4 center toward zero
    assign cxe = BASE_W'(s_center_x);
    assign cye = BASE_W'(s_center_y);
    assign ncx = -cxe;
    assign ncy = -cye;
    assign tcx = s_center_x[COORD_W-1] ? -{ncx[BASE_W-1:4], 4'b0} : {cxe[BASE_W-1:4], 4'b0};
    assign tcy = s_center_y[COORD_W-1] ? -{ncy[BASE_W-1:4], 4'b0} : {cye[BASE_W-1:4], 4'b0};

    // Unrotated offset of the current vertex
    assign hw = OP_W'(signed'({1'b0, w_reg, 3'b0}));
    assign hh = OP_W'(signed'({1'b0, h_reg, 3'b0}));
    assign r4 = OP_W'(signed'({1'b0, w_reg[SIZE_W-1:1], 4'b0}));

    always_comb begin
        op_x = '0;
        op_y = '0;
        unique case (kind_reg)
            KIND_RECT: begin
                unique case (vtx_reg[1:0])
                    2'd0:    begin op_x = -hw; op_y = -hh; end
                    2'd1:    begin op_x = hw;  op_y = -hh; end
                    2'd2:    begin op_x = hw;  op_y = hh;  end
                    default: begin op_x = -hw; op_y = hh;  end
                endcase
            end
            KIND_TRI: begin
                unique case (vtx_reg[1:0])
                    2'd0:    begin op_x = '0;  op_y = -hw; end
                    2'd1:    begin op_x = -hw; op_y = hw;  end
                    default: begin op_x = hw;  op_y = hw;  end
                endcase
            end
            KIND_CIRCLE: begin
                op_x = r4;
                op_y = '0;
            end
            default: begin
                op_x = '0;
                op_y = '0;
            end
        endcase
    end

    // Shared multiplier operand select
    always_comb begin
        unique case (step_reg)
            3'd0:    begin mul_a = op_x; mul_b = cos_v; end
            3'd1:    begin mul_a = op_y; mul_b = sin_v; end
            3'd2:    begin mul_a = op_x; mul_b = sin_v; end
            3'd3:    begin mul_a = op_y; mul_b = cos_v; end
            default: begin mul_a = op_x; mul_b = cos_v; end
        endcase
    end

    assign prod_next  = PROD_W'(mul_a * mul_b);
    assign cord_angle = (kind_reg == KIND_CIRCLE) ? a_reg + off_reg[ANG_W-1:0] : a_reg;
    assign rem_sum    = rem_reg + REM_W'(OFF_FRAC);

    // Finish: round, add center, saturate; rim texture from cos/sin
    function automatic logic signed [COORD_W-1:0] sat_pos(
        input logic signed [BASE_W-1:0] base,
        input logic signed [ACC_W-1:0]  acc
    );
        logic signed [SUM_W-1:0] sum;
        begin
            sum = SUM_W'(base) + SUM_W'(signed'(acc[ACC_W-1:30]));
            if (sum > SUM_W'(524287))
                return 20'sd524287;
            else if (sum < -SUM_W'(524288))
                return -20'sd524288;
            else
                return sum[COORD_W-1:0];
        end
    endfunction

    function automatic logic [TEX_W-1:0] tex_of(input logic signed [CS_W-1:0] t);
        logic signed [CS_W:0] rt;
        logic signed [11:0]   tv;
        begin
            rt = (CS_W+1)'(t) + (CS_W+1)'(34'sd4194304);
            tv = 12'(signed'(rt[CS_W:23])) + 12'sd128;
            if (tv < 12'sd0)
                return '0;
            else if (tv > 12'sd256)
                return 9'd256;
            else
                return tv[TEX_W-1:0];
        end
    endfunction

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        a_next      = a_reg;
        rgba_next   = rgba_reg;
        vtx_next    = vtx_reg;
        step_next   = step_reg;
        count_next  = count_reg;
        off_next    = off_reg;
        rem_next    = rem_reg;
        acc_next    = acc_reg;
        accx_next   = accx_reg;
        accy_next   = accy_reg;
        px_out_next = px_out_reg;
        py_out_next = py_out_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        last_next   = last_reg;
        cord_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next = kind_t'(s_shape_kind);
                    w_next    = s_size_w;
                    h_next    = s_size_h;
                    a_next    = {s_angle, 4'b0};
                    rgba_next = s_highlight ? YELLOW : s_rgba;
                    vtx_next  = '0;
                    step_next = '0;
                    off_next  = '0;
                    rem_next  = REM_W'(RIM_SIDES / 2);
                    if (s_restart)
                        count_next = '0;
                    unique case (kind_t'(s_shape_kind))
                        KIND_CIRCLE: begin
                            bx_next    = tcx;
                            by_next    = tcy;
                            accx_next  = HALF;
                            accy_next  = HALF;
                            state_next = ST_FIN;
                        end
                        KIND_RECT, KIND_TRI: begin
                            bx_next    = cxe;
                            by_next    = cye;
                            state_next = ST_CSTART;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CSTART: begin
                cord_start = 1'b1;
                state_next = ST_CWAIT;
            end
            ST_CWAIT: begin
                step_next = '0;
                if (cord_done)
                    state_next = ST_MUL;
            end
            ST_MUL: begin
                step_next = step_reg + 3'd1;
                unique case (step_reg)
                    3'd1:    acc_next = prod_reg;
                    3'd2:    accx_next = ACC_W'(acc_reg) - ACC_W'(prod_reg) + HALF;
                    3'd3:    acc_next = prod_reg;
                    3'd4: begin
                        accy_next  = ACC_W'(acc_reg) + ACC_W'(prod_reg) + HALF;
                        state_next = ST_FIN;
                    end
                    default: acc_next = acc_reg;
                endcase
            end
            ST_FIN: begin
                px_out_next = sat_pos(bx_reg, accx_reg);
                py_out_next = sat_pos(by_reg, accy_reg);
                u_next      = '0;
                v_next      = '0;
                last_next   = 1'b0;
                unique case (kind_reg)
                    KIND_CIRCLE: begin
                        if (vtx_reg == '0) begin
                            u_next = 9'd128;
                            v_next = 9'd128;
                        end else begin
                            u_next = tex_of(cos_v);
                            v_next = tex_of(sin_v);
                        end
                        last_next = (vtx_reg == VTX_CIRC_LAST);
                    end
                    KIND_RECT: last_next = (vtx_reg == VTX_W'(3));
                    KIND_TRI:  last_next = (vtx_reg == VTX_W'(2));
                    default:   last_next = 1'b1;
                endcase
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    count_next = count_reg + IDX_W'(1);
                    vtx_next   = vtx_reg + VTX_W'(1);
                    step_next  = '0;
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end else if (kind_reg == KIND_CIRCLE) begin
                        // Advance the rim angle after each rim point
                        if (vtx_reg != '0) begin
                            if (rem_sum >= REM_W'(RIM_SIDES)) begin
                                rem_next = rem_sum - REM_W'(RIM_SIDES);
                                off_next = off_reg + (ANG_W+1)'(OFF_STEP + 1);
                            end else begin
                                rem_next = rem_sum;
                                off_next = off_reg + (ANG_W+1)'(OFF_STEP);
                            end
                        end
                        state_next = ST_CSTART;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        kind_reg   <= kind_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        a_reg      <= a_next;
        rgba_reg   <= rgba_next;
        vtx_reg    <= vtx_next;
        step_reg   <= step_next;
        off_reg    <= off_next;
        rem_reg    <= rem_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        accx_reg   <= accx_next;
        accy_reg   <= accy_next;
        px_out_reg <= px_out_next;
        py_out_reg <= py_out_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        last_reg   <= last_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = (state_reg == ST_OUT);
    assign m_vertex_index = count_reg;
    assign m_pos_x        = px_out_reg;
    assign m_pos_y        = py_out_reg;
    assign m_tex_u        = u_reg;
    assign m_tex_v        = v_reg;
    assign m_vertex_rgba  = rgba_reg;
    assign m_last         = last_reg;

    // Input and output sides never overlap
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while a vertex is pending");

    // An empty shape frees the input at once
    a_none: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_shape_kind == KIND_NONE) |=> s_ready)
        else $error("empty shape did not return to idle");

    // More vertices follow a non-final word
    a_more: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> !s_ready)
        else $error("shape ended before its last vertex");

    // Index advances by one between words of a shape
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=>
            (m_vertex_index == $past(m_vertex_index) + 16'd1))
        else $error("vertex index skipped");

endmodule
